FILE: src/bpskm_pkg.sv
// Shared constants, types and the quarter-wave cosine table for the BPSK modulator.
package bpskm_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int TABLE_ADDR_BITS = 10;
   localparam int SAMPLE_BITS     = 16;

   localparam int QTR_N       = 1 << TABLE_ADDR_BITS;
   localparam int TABLE_DEPTH = QTR_N + 1;
   localparam int TIDX_BITS   = TABLE_ADDR_BITS + 1;

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int SPS_BITS       = 16;
   localparam int LFSR_BITS      = 9;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_STEP         = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SAMPLES_PER_SYMBOL = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LFSR_SEED          = 2'd2;

   localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET = PHASE_BITS'(64'd429496730);
   localparam logic [SPS_BITS-1:0]   SPS_RESET        = 16'd400;
   localparam logic [LFSR_BITS-1:0]  SEED_RESET       = 9'd250;

   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   typedef logic [SAMPLE_BITS-1:0] cos_table_type [0:TABLE_DEPTH-1];

   // term n of the Taylor series is divided by (2n-1)(2n)
   function automatic logic [63:0] taylor_div(input int n, input logic [63:0] v);
      logic [63:0] r;
      begin
         case (n)
            1:       r = v / 64'd2;
            2:       r = v / 64'd12;
            3:       r = v / 64'd30;
            4:       r = v / 64'd56;
            5:       r = v / 64'd90;
            6:       r = v / 64'd132;
            7:       r = v / 64'd182;
            8:       r = v / 64'd240;
            9:       r = v / 64'd306;
            default: r = v / 64'd380;
         endcase
         return r;
      end
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] cos_entry(input int k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] c;
      logic [63:0]        amp;
      logic [63:0]        r;
      begin
         x    = (PI_HALF_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         c    = signed'(term);
         amp  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
         for (int n = 1; n <= 10; n++) begin
            term = taylor_div(n, (term * x2) >> 30);
            if ((n % 2) == 1) begin
               c = c - signed'(term);
            end else begin
               c = c + signed'(term);
            end
         end
         if (c < 0) begin
            c = 0;
         end
         r = ((unsigned'(c) * amp) + (64'd1 << 29)) >> 30;
         return r[SAMPLE_BITS-1:0];
      end
   endfunction

   function automatic cos_table_type build_cos_table();
      cos_table_type t;
      begin
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            t[k] = cos_entry(k);
         end
         return t;
      end
   endfunction

   localparam cos_table_type COS_TABLE = build_cos_table();

endpackage

FILE: src/bpsk_modulator_prbs9_core.sv
// BPSK sample generator with PRBS9 data: phase accumulator, cosine lookup, symbol timing.
// A result passes through the table read stage, then the output register; rsp_stall can hold it in either.
// Throughput: one request per cycle while req_stall is low; the single read port of the cosine RAM sets that rate.
// Reset: configuration registers take their defaults, phase and symbol count clear,
// the shift register loads the default seed, and a pass over all 1025 entries loads the
// cosine RAM from the table; req_stall stays high until that pass ends.
module bpsk_modulator_prbs9_core (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_wr_en,
   input  logic [bpskm_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [bpskm_pkg::CSR_DATA_BITS-1:0]         csr_data,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic                                        req_restart,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [bpskm_pkg::SAMPLE_BITS-1:0]    rsp_sample,
   output logic                                        rsp_data_bit,
   output logic                                        rsp_symbol_start
);

   localparam int PB = bpskm_pkg::PHASE_BITS;
   localparam int TB = bpskm_pkg::TABLE_ADDR_BITS;
   localparam int SB = bpskm_pkg::SAMPLE_BITS;
   localparam int IB = bpskm_pkg::TIDX_BITS;
   localparam int CB = bpskm_pkg::SPS_BITS;
   localparam int LB = bpskm_pkg::LFSR_BITS;

   // configuration
   logic [PB-1:0] step_ff, step_in;
   logic [CB-1:0] sps_ff, sps_in;
   logic [LB-1:0] seed_ff, seed_in;

   // generator state
   logic [PB-1:0] phase_ff, phase_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [LB-1:0] lfsr_ff, lfsr_in;
   logic          bit_ff, bit_in;

   // table fill
   logic          filling_ff, filling_in;
   logic [IB-1:0] fill_cnt_ff, fill_cnt_in;

   // table read stage
   logic          a_valid_ff, a_valid_in;
   logic          a_neg_ff, a_neg_in;
   logic          a_bit_ff, a_bit_in;
   logic          a_start_ff, a_start_in;

   // output register
   logic          o_valid_ff, o_valid_in;
   logic [SB-1:0] o_sample_ff, o_sample_in;
   logic          o_bit_ff, o_bit_in;
   logic          o_start_ff, o_start_in;

   logic          advance;
   logic          req_fire;
   logic [PB-1:0] phase_eff;
   logic [CB-1:0] cnt_eff, cnt_inc;
   logic [LB-1:0] lfsr_eff;
   logic          start;
   logic          cur_bit;
   logic [1:0]    quad;
   logic [TB-1:0] taddr;
   logic [IB-1:0] tidx;
   logic [SB-1:0] mag;

   assign advance   = !o_valid_ff || !rsp_stall;
   assign req_stall = filling_ff || (a_valid_ff && !advance);
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      step_in = step_ff;
      sps_in  = sps_ff;
      seed_in = seed_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bpskm_pkg::REG_PHASE_STEP:         step_in = PB'(csr_data);
            bpskm_pkg::REG_SAMPLES_PER_SYMBOL: sps_in  = csr_data[CB-1:0];
            bpskm_pkg::REG_LFSR_SEED:          seed_in = csr_data[LB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_eff = req_restart ? '0 : phase_ff;
      cnt_eff   = req_restart ? '0 : cnt_ff;
      lfsr_eff  = req_restart ? seed_ff : lfsr_ff;
      start     = (cnt_eff == '0);
      cur_bit   = start ? lfsr_eff[2] : bit_ff;
      cnt_inc   = cnt_eff + CB'(1);
      quad      = phase_eff[PB-1 -: 2];
      taddr     = phase_eff[PB-3 -: TB];
      tidx      = quad[0] ? (IB'(bpskm_pkg::QTR_N) - IB'(taddr)) : IB'(taddr);

      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      lfsr_in  = lfsr_ff;
      bit_in   = bit_ff;
      if (req_fire) begin
         phase_in = phase_eff + step_ff;
         cnt_in   = (cnt_inc >= sps_ff) ? '0 : cnt_inc;
         lfsr_in  = start ? {lfsr_eff[4] ^ lfsr_eff[0], lfsr_eff[LB-1:1]} : lfsr_eff;
         bit_in   = cur_bit;
      end
   end

   always_comb begin
      fill_cnt_in = fill_cnt_ff;
      filling_in  = filling_ff;
      if (filling_ff) begin
         fill_cnt_in = fill_cnt_ff + IB'(1);
         if (fill_cnt_ff == IB'(bpskm_pkg::QTR_N)) begin
            filling_in = 1'b0;
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      a_neg_in   = a_neg_ff;
      a_bit_in   = a_bit_ff;
      a_start_in = a_start_ff;
      if (req_fire) begin
         a_valid_in = 1'b1;
         a_neg_in   = ((quad == 2'd1) || (quad == 2'd2)) ^ !cur_bit;
         a_bit_in   = cur_bit;
         a_start_in = start;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      o_valid_in  = o_valid_ff;
      o_sample_in = o_sample_ff;
      o_bit_in    = o_bit_ff;
      o_start_in  = o_start_ff;
      if (advance) begin
         o_valid_in  = a_valid_ff;
         o_sample_in = a_neg_ff ? (SB'(0) - mag) : mag;
         o_bit_in    = a_bit_ff;
         o_start_in  = a_start_ff;
      end
   end

   bpskm_ram #(
      .WIDTH (SB),
      .DEPTH (bpskm_pkg::TABLE_DEPTH)
   ) u_cos_ram (
      .clock   (clock),
      .wr_en   (filling_ff),
      .wr_addr (fill_cnt_ff),
      .wr_data (bpskm_pkg::COS_TABLE[fill_cnt_ff]),
      .rd_en   (req_fire),
      .rd_addr (tidx),
      .rd_data (mag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= bpskm_pkg::PHASE_STEP_RESET;
         sps_ff      <= bpskm_pkg::SPS_RESET;
         seed_ff     <= bpskm_pkg::SEED_RESET;
         phase_ff    <= '0;
         cnt_ff      <= '0;
         lfsr_ff     <= bpskm_pkg::SEED_RESET;
         bit_ff      <= 1'b0;
         filling_ff  <= 1'b1;
         fill_cnt_ff <= '0;
         a_valid_ff  <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         step_ff     <= step_in;
         sps_ff      <= sps_in;
         seed_ff     <= seed_in;
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         lfsr_ff     <= lfsr_in;
         bit_ff      <= bit_in;
         filling_ff  <= filling_in;
         fill_cnt_ff <= fill_cnt_in;
         a_valid_ff  <= a_valid_in;
         o_valid_ff  <= o_valid_in;
      end
      a_neg_ff    <= a_neg_in;
      a_bit_ff    <= a_bit_in;
      a_start_ff  <= a_start_in;
      o_sample_ff <= o_sample_in;
      o_bit_ff    <= o_bit_in;
      o_start_ff  <= o_start_in;
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_sample       = signed'(o_sample_ff);
   assign rsp_data_bit     = o_bit_ff;
   assign rsp_symbol_start = o_start_ff;

`ifndef ASSERT_OFF
   a_no_req_during_fill: assert property (@(posedge clock) disable iff (reset)
      filling_ff |-> req_stall)
      else $error("request accepted while cosine RAM loads");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filling_ff |-> (fill_cnt_ff <= IB'(bpskm_pkg::QTR_N)))
      else $error("fill counter past table end");

   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (o_sample_ff != {1'b1, {(SB-1){1'b0}}}))
      else $error("sample outside full-scale range");

   a_short_symbol: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (sps_ff <= CB'(1))) |=> (cnt_ff == '0))
      else $error("symbol counter did not wrap on one-sample symbols");
`endif

endmodule

FILE: src/bpskm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpskm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
